@@ rtl/hgc_pkg.sv @@
// hgc_pkg: shared constants, register codes and pipeline types for the
// hdr ghost certainty pixel block; no dependencies
package hgc_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int TIDX_W      = $clog2(TABLE_DEPTH);

	localparam int PIX_W   = 16;
	localparam int CERT_W  = 17;
	localparam int TI_W    = 8;
	localparam int CFG_I_W = 2;

	localparam int DIV_STEPS = 4;

	localparam logic [CERT_W-1:0] ONE_Q1_16 = 17'h10000;
	localparam logic [PIX_W-1:0]  SAT_Q8_8  = 16'hFF00;

	localparam logic [CFG_I_W-1:0] REG_FIRST_IS_REF = 2'd0;
	localparam logic [CFG_I_W-1:0] REG_RATIO        = 2'd1;
	localparam logic [CFG_I_W-1:0] REG_LOW_THR      = 2'd2;
	localparam logic [CFG_I_W-1:0] REG_HIGH_THR     = 2'd3;

	localparam logic [PIX_W-1:0] RST_RATIO    = 16'd512;
	localparam logic [PIX_W-1:0] RST_LOW_THR  = 16'd768;
	localparam logic [PIX_W-1:0] RST_HIGH_THR = 16'd64768;

	typedef struct packed {
		logic             first_is_reference;
		logic [PIX_W-1:0] exposure_ratio;
		logic [PIX_W-1:0] low_threshold;
		logic [PIX_W-1:0] high_threshold;
	} cfg_t;

	typedef struct packed {
		logic              cmd;
		logic [PIX_W-1:0]  meas;
		logic [23:0]       prod;
		logic              ovf;
		logic [PIX_W-1:0]  rem;
		logic [PIX_W-1:0]  bits;
		logic [PIX_W-1:0]  quo;
		logic              one;
		logic [TI_W-1:0]   tidx;
		logic [CERT_W-1:0] tval;
	} pipe_t;

endpackage

@@ rtl/hdr_ghost_certainty_pixel_top.sv @@
// Ghost certainty pipeline for hdr merging: one item accepted per clock
// while the output is not held, a table write produces no result. The
// path holds the 16-bit divider (four stages of four quotient bits), the
// multiplier stage and the registered read of the gaussian table memory.
// Stages advance independently, so bubbles close up and requests keep
// flowing into free stages while a result waits at the output.
// Configuration must be written by the user only while idle; the block
// does not enforce it. Table entries must be written before they are
// read. Depends on hgc_pkg, hgc_cfg_regs, hgc_div_stage and hgc_ram.
module hdr_ghost_certainty_pixel_top
	import hgc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_I_W-1:0] cfg_index,
	input  logic [PIX_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [PIX_W-1:0]   first_pixel,
	input  logic [PIX_W-1:0]   second_pixel,
	input  logic [TI_W-1:0]    table_index,
	input  logic [CERT_W-1:0]  table_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CERT_W-1:0]  certainty
);

	cfg_t cfg;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, out_valid_q;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6, ld_s7, ld_out;

	logic              cmd_s1;
	logic [PIX_W-1:0]  first_s1, second_s1;
	logic [TI_W-1:0]   tidx_s1;
	logic [CERT_W-1:0] tval_s1;

	pipe_t pipe_s2, pipe_s3, pipe_s4, pipe_s5, pipe_s6;
	pipe_t init_c;

	logic              cmd_s7, one_s7, inrange_s7;
	logic [CERT_W-1:0] certainty_q;

	logic [PIX_W-1:0]  ref_c, meas_c, pred_c, diff_c;
	logic [31:0]       prod_c;
	logic [TI_W-1:0]   rd_idx_c;
	logic              rd_ok_c, wr_ok_c;
	logic              ram_we, ram_re;
	logic [CERT_W-1:0] ram_rdata;

	hgc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage advance, bubbles collapse
	assign ld_out   = !out_valid_q || out_ready;
	assign ld_s7    = !v_s7 || cmd_s7 || ld_out;
	assign ld_s6    = !v_s6 || ld_s7;
	assign ld_s5    = !v_s5 || ld_s6;
	assign ld_s4    = !v_s4 || ld_s5;
	assign ld_s3    = !v_s3 || ld_s4;
	assign ld_s2    = !v_s2 || ld_s3;
	assign ld_s1    = !v_s1 || ld_s2;
	assign in_ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1)  v_s1 <= in_valid;
			if (ld_s2)  v_s2 <= v_s1;
			if (ld_s3)  v_s3 <= v_s2;
			if (ld_s4)  v_s4 <= v_s3;
			if (ld_s5)  v_s5 <= v_s4;
			if (ld_s6)  v_s6 <= v_s5;
			if (ld_s7)  v_s7 <= v_s6;
			if (ld_out) out_valid_q <= v_s7 && !cmd_s7;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			cmd_s1    <= cmd;
			first_s1  <= first_pixel;
			second_s1 <= second_pixel;
			tidx_s1   <= table_index;
			tval_s1   <= table_value;
		end
	end

	// multiply and divider setup
	always_comb begin
		ref_c  = cfg.first_is_reference ? first_s1 : second_s1;
		meas_c = cfg.first_is_reference ? second_s1 : first_s1;
		prod_c = 32'(ref_c) * 32'(cfg.exposure_ratio);

		init_c.cmd  = cmd_s1;
		init_c.meas = meas_c;
		init_c.prod = prod_c[31:8];
		init_c.ovf  = (cfg.exposure_ratio[15:8] == 8'd0) &&
			(ref_c[15:8] >= cfg.exposure_ratio[7:0]);
		init_c.rem  = {8'd0, ref_c[15:8]};
		init_c.bits = {ref_c[7:0], 8'd0};
		init_c.quo  = '0;
		init_c.one  = (ref_c < cfg.low_threshold && meas_c < cfg.low_threshold) ||
			(!cfg.first_is_reference && ref_c > cfg.high_threshold);
		init_c.tidx = tidx_s1;
		init_c.tval = tval_s1;
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			pipe_s2 <= init_c;
		end
	end

	hgc_div_stage u_div0 (
		.clk(clk), .en(ld_s3), .ratio(cfg.exposure_ratio), .d(pipe_s2), .q(pipe_s3)
	);
	hgc_div_stage u_div1 (
		.clk(clk), .en(ld_s4), .ratio(cfg.exposure_ratio), .d(pipe_s3), .q(pipe_s4)
	);
	hgc_div_stage u_div2 (
		.clk(clk), .en(ld_s5), .ratio(cfg.exposure_ratio), .d(pipe_s4), .q(pipe_s5)
	);
	hgc_div_stage u_div3 (
		.clk(clk), .en(ld_s6), .ratio(cfg.exposure_ratio), .d(pipe_s5), .q(pipe_s6)
	);

	// prediction, difference and table address
	always_comb begin
		if (cfg.first_is_reference) begin
			pred_c = (pipe_s6.prod > 24'(SAT_Q8_8)) ? SAT_Q8_8 : pipe_s6.prod[15:0];
		end else if (pipe_s6.ovf || pipe_s6.quo > cfg.high_threshold) begin
			pred_c = cfg.high_threshold;
		end else begin
			pred_c = pipe_s6.quo;
		end
		diff_c   = (pipe_s6.meas > pred_c) ? (pipe_s6.meas - pred_c) : (pred_c - pipe_s6.meas);
		rd_idx_c = diff_c[15:8];
		rd_ok_c  = 32'(rd_idx_c) < 32'(TABLE_DEPTH);
		wr_ok_c  = 32'(pipe_s6.tidx) < 32'(TABLE_DEPTH);
	end

	assign ram_we = ld_s7 && v_s6 && pipe_s6.cmd && wr_ok_c;
	assign ram_re = ld_s7 && v_s6 && !pipe_s6.cmd;

	hgc_ram #(
		.WIDTH (CERT_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (TIDX_W'(pipe_s6.tidx)),
		.wdata (pipe_s6.tval),
		.re    (ram_re),
		.raddr (TIDX_W'(rd_idx_c)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ld_s7) begin
			cmd_s7     <= pipe_s6.cmd;
			one_s7     <= pipe_s6.one;
			inrange_s7 <= rd_ok_c;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ld_out) begin
			priority if (one_s7) begin
				certainty_q <= ONE_Q1_16;
			end else if (inrange_s7) begin
				certainty_q <= ram_rdata;
			end else begin
				certainty_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign certainty = certainty_q;

`ifndef SYNTH
	a_rose_from_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s7 && !cmd_s7))
		else $error("result raised without a pixel in the table stage");

	a_ram_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("table read and write in the same cycle");

	a_s1_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with empty input stage");

	a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !ld_s7) |=> v_s6)
		else $error("item lost at table stage during stall");
`endif

endmodule

@@ rtl/hgc_ram.sv @@
// hgc_ram: generic simple dual-port ram, one write and one registered read
// port; no dependencies
module hgc_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/hgc_cfg_regs.sv @@
// hgc_cfg_regs: configuration register file written over the cfg request
// channel; depends on hgc_pkg
module hgc_cfg_regs
	import hgc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_I_W-1:0] cfg_index,
	input  logic [PIX_W-1:0]   cfg_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_is_reference <= 1'b1;
			cfg_q.exposure_ratio     <= RST_RATIO;
			cfg_q.low_threshold      <= RST_LOW_THR;
			cfg_q.high_threshold     <= RST_HIGH_THR;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FIRST_IS_REF: cfg_q.first_is_reference <= cfg_data[0];
				REG_RATIO:        cfg_q.exposure_ratio     <= cfg_data;
				REG_LOW_THR:      cfg_q.low_threshold      <= cfg_data;
				REG_HIGH_THR:     cfg_q.high_threshold     <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/hgc_div_stage.sv @@
// hgc_div_stage: one registered stage of the restoring divider, several
// quotient bits per stage; depends on hgc_pkg
module hgc_div_stage
	import hgc_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [PIX_W-1:0] ratio,
	input  pipe_t            d,
	output pipe_t            q
);

	pipe_t nxt;

	always_comb begin
		logic [PIX_W:0]   t;
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] b;
		logic [PIX_W-1:0] qq;
		r  = d.rem;
		b  = d.bits;
		qq = d.quo;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t = {r, b[PIX_W-1]};
			b = {b[PIX_W-2:0], 1'b0};
			if (t >= {1'b0, ratio}) begin
				r  = PIX_W'(t - {1'b0, ratio});
				qq = {qq[PIX_W-2:0], 1'b1};
			end else begin
				r  = t[PIX_W-1:0];
				qq = {qq[PIX_W-2:0], 1'b0};
			end
		end
		nxt      = d;
		nxt.rem  = r;
		nxt.bits = b;
		nxt.quo  = qq;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

@@ dv/hgc_tb_pkg.sv @@
// hgc_tb_pkg: request codes shared by the ghost certainty testbench top and its checker
// no dependencies
`timescale 1ns / 100ps
package hgc_tb_pkg;

	typedef enum logic [0:0] {
		CMD_PIXEL       = 1'b0,
		CMD_TABLE_WRITE = 1'b1
	} cmd_e;

endpackage

@@ dv/hgc_certainty_checker.sv @@
// hgc_certainty_checker: watches the config, request and result channels of the ghost
// certainty block, predicts each certainty and compares it; depends on hgc_pkg, hgc_tb_pkg
`timescale 1ns / 100ps
module hgc_certainty_checker
	import hgc_pkg::*;
	import hgc_tb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CFG_I_W-1:0] cfg_index,
	input  logic [PIX_W-1:0]   cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               cmd,
	input  logic [PIX_W-1:0]   first_pixel,
	input  logic [PIX_W-1:0]   second_pixel,
	input  logic [TI_W-1:0]    table_index,
	input  logic [CERT_W-1:0]  table_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [CERT_W-1:0]  certainty,
	output int                 fail_count,
	output int                 outstanding,
	output int                 compared
);

	logic              ref_first;
	logic [PIX_W-1:0]  ratio;
	logic [PIX_W-1:0]  low_thr;
	logic [PIX_W-1:0]  high_thr;
	logic [CERT_W-1:0] gauss_copy [TABLE_DEPTH];
	logic [CERT_W-1:0] certainty_due [$];
	int                errors = 0;
	int                seen = 0;

	assign fail_count = errors;
	assign compared   = seen;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		errors++;
	endtask

	function automatic logic [CERT_W-1:0] certainty_for(input logic [PIX_W-1:0] p0,
			input logic [PIX_W-1:0] p1);
		logic [31:0] refv;
		logic [31:0] meas;
		logic [31:0] pred;
		logic [31:0] diff;
		refv = ref_first ? p0 : p1;
		meas = ref_first ? p1 : p0;
		if (refv < low_thr && meas < low_thr)
			return ONE_Q1_16;
		if (ref_first) begin
			pred = (refv * ratio) >> 8;
			if (pred > SAT_Q8_8)
				pred = SAT_Q8_8;
		end else begin
			if (refv > high_thr)
				return ONE_Q1_16;
			pred = (ratio == '0) ? 32'hFFFF_FFFF : (refv << 8) / ratio;
			if (pred > high_thr)
				pred = high_thr;
		end
		diff = (meas > pred) ? meas - pred : pred - meas;
		if ((diff >> 8) < TABLE_DEPTH)
			return gauss_copy[diff >> 8];
		return '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [CERT_W-1:0] want;
		if (!arst_n) begin
			ref_first = 1'b1;
			ratio     = RST_RATIO;
			low_thr   = RST_LOW_THR;
			high_thr  = RST_HIGH_THR;
			certainty_due.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FIRST_IS_REF: ref_first = cfg_data[0];
					REG_RATIO:        ratio     = cfg_data;
					REG_LOW_THR:      low_thr   = cfg_data;
					REG_HIGH_THR:     high_thr  = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (certainty_due.size() == 0) begin
					report_mismatch($sformatf("certainty %0d with no request waiting", certainty));
				end else begin
					want = certainty_due.pop_front();
					seen++;
					if (certainty !== want)
						report_mismatch($sformatf("certainty %0d, expected %0d", certainty, want));
				end
			end
			if (in_valid && in_ready) begin
				if (cmd == CMD_TABLE_WRITE) begin
					if (table_index < TABLE_DEPTH)
						gauss_copy[table_index] = table_value;
				end else begin
					certainty_due.insert(certainty_due.size(),
						certainty_for(first_pixel, second_pixel));
				end
			end
			outstanding <= certainty_due.size();
		end
	end

endmodule

@@ dv/hdr_ghost_certainty_pixel_top_tb.sv @@
// hdr_ghost_certainty_pixel_top_tb: loads the gaussian table, drives directed and random
// pixel and table requests over several register settings; depends on hgc_pkg, hgc_tb_pkg,
// hgc_certainty_checker and the ghost certainty block
`timescale 1ns / 100ps
module hdr_ghost_certainty_pixel_top_tb;
	import hgc_pkg::*;
	import hgc_tb_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 4000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_I_W-1:0] cfg_index;
	logic [PIX_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               cmd;
	logic [PIX_W-1:0]   first_pixel;
	logic [PIX_W-1:0]   second_pixel;
	logic [TI_W-1:0]    table_index;
	logic [CERT_W-1:0]  table_value;
	logic               out_valid;
	logic               out_ready;
	logic [CERT_W-1:0]  certainty;
	int                 fail_count;
	int                 outstanding;
	int                 compared;

	logic               steady;
	logic               hold_req;
	logic               cur_first;
	logic [PIX_W-1:0]   cur_ratio;
	logic [PIX_W-1:0]   cur_low;
	logic [PIX_W-1:0]   cur_high;
	int                 pixels;
	int                 writes;
	int                 settings;

	hdr_ghost_certainty_pixel_top dut (.*);

	hgc_certainty_checker u_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		cmd          = CMD_PIXEL;
		first_pixel  = '0;
		second_pixel = '0;
		table_index  = '0;
		table_value  = '0;
		out_ready    = 1'b0;
		steady       = 1'b0;
		hold_req     = 1'b0;
		cur_first    = 1'b1;
		cur_ratio    = RST_RATIO;
		cur_low      = RST_LOW_THR;
		cur_high     = RST_HIGH_THR;
		pixels       = 0;
		writes       = 0;
		settings     = 0;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(0, 99) >= 32);
			end
		end
	end

	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall = 0;
			else
				stall++;
		end
		$display("watchdog: no request accepted for %0d cycles", stall);
		$display("FAIL hdr_ghost_certainty_pixel_top");
		$finish;
	end

	function automatic logic [CERT_W-1:0] pick_table_value();
		return ($urandom_range(0, 9) == 0) ? ONE_Q1_16 : CERT_W'($urandom);
	endfunction

	task automatic send_item(input cmd_e c, input logic [PIX_W-1:0] p0,
			input logic [PIX_W-1:0] p1, input logic [TI_W-1:0] ti,
			input logic [CERT_W-1:0] tv);
		while (!steady && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		first_pixel  <= p0;
		second_pixel <= p1;
		table_index  <= ti;
		table_value  <= tv;
		do @(posedge clk); while (!in_ready);
		if (c == CMD_TABLE_WRITE)
			writes++;
		else
			pixels++;
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] p0, input logic [PIX_W-1:0] p1);
		send_item(CMD_PIXEL, p0, p1, TI_W'($urandom), CERT_W'($urandom));
	endtask

	task automatic send_write(input logic [TI_W-1:0] ti, input logic [CERT_W-1:0] tv);
		send_item(CMD_TABLE_WRITE, PIX_W'($urandom), PIX_W'($urandom), ti, tv);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_I_W-1:0] idx, input logic [PIX_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_setting(input logic mode, input logic [PIX_W-1:0] ratio_v,
			input logic [PIX_W-1:0] low_v, input logic [PIX_W-1:0] high_v);
		logic [PIX_W-1:0] mode_word;
		drain();
		mode_word    = PIX_W'($urandom);
		mode_word[0] = mode;
		write_reg(REG_FIRST_IS_REF, mode_word);
		write_reg(REG_RATIO, ratio_v);
		write_reg(REG_LOW_THR, low_v);
		write_reg(REG_HIGH_THR, high_v);
		cfg_valid <= 1'b0;
		cur_first = mode;
		cur_ratio = ratio_v;
		cur_low   = low_v;
		cur_high  = high_v;
		settings++;
	endtask

	task automatic random_request();
		longint           refv;
		longint           meas;
		longint           guess;
		logic [PIX_W-1:0] p0;
		logic [PIX_W-1:0] p1;
		if ($urandom_range(0, 99) < 15) begin
			send_write(TI_W'($urandom), pick_table_value());
			return;
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				p0 = PIX_W'($urandom);
				p1 = PIX_W'($urandom);
			end
			4, 5, 6: begin
				// measured value close to what the reference predicts
				refv = longint'($urandom_range(0, 65535) >> $urandom_range(0, 8));
				if (cur_first) begin
					guess = (refv * cur_ratio) >> 8;
					if (guess > 65280)
						guess = 65280;
				end else begin
					guess = (cur_ratio == 0) ? cur_high : (refv * 256) / cur_ratio;
					if (guess > cur_high)
						guess = cur_high;
				end
				meas = guess + longint'($urandom_range(0, 6000)) - 3000;
				if (meas < 0)
					meas = 0;
				if (meas > 65535)
					meas = 65535;
				p0 = cur_first ? PIX_W'(refv) : PIX_W'(meas);
				p1 = cur_first ? PIX_W'(meas) : PIX_W'(refv);
			end
			7: begin
				p0 = PIX_W'(cur_low + $urandom_range(0, 1023) - 512);
				p1 = PIX_W'(cur_low + $urandom_range(0, 1023) - 512);
			end
			8: begin
				p0 = PIX_W'(cur_high + $urandom_range(0, 1023) - 512);
				p1 = PIX_W'(cur_high + $urandom_range(0, 1023) - 512);
				if ($urandom_range(0, 1) == 0)
					p0 = PIX_W'($urandom);
				else
					p1 = PIX_W'($urandom);
			end
			default: begin
				p0 = ($urandom_range(0, 1) == 0) ? '0 : '1;
				p1 = ($urandom_range(0, 1) == 0) ? '0 : '1;
			end
		endcase
		send_pixel(p0, p1);
	endtask

	initial begin : stimulus
		logic [CERT_W-1:0] tv;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every table entry is loaded before any pixel can read it
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			case (i)
				1:       tv = ONE_Q1_16;
				2:       tv = '0;
				3:       tv = '1;
				default: tv = pick_table_value();
			endcase
			send_write(TI_W'(i), tv);
		end

		// reset settings, multiply mode
		send_pixel(16'h0000, 16'h0000);
		send_pixel(16'd767, 16'd767);
		send_pixel(16'd767, 16'd768);
		send_pixel(16'h1000, 16'h2000);
		send_write(8'd0, 17'h1FFFF);
		send_pixel(16'h1000, 16'h2000);
		send_pixel(16'hFFFF, 16'hFFFF);
		send_pixel(16'hFFFF, 16'h0000);
		send_pixel(16'h0000, 16'hFFFF);
		send_pixel(16'h8000, 16'h0000);

		// divide mode, overexposed reference and its boundary
		apply_setting(1'b0, RST_RATIO, RST_LOW_THR, RST_HIGH_THR);
		send_pixel(16'h1234, 16'hFFFF);
		send_pixel(16'h1234, RST_HIGH_THR);
		send_pixel(16'hFFFF, 16'h0200);
		send_pixel(16'h0100, 16'h0100);
		send_pixel(16'h0000, 16'h4000);

		// zero ratio in divide mode
		apply_setting(1'b0, 16'd0, RST_LOW_THR, 16'h8000);
		send_pixel(16'h8000, 16'h0400);
		send_pixel(16'h0000, 16'h7FFF);
		send_pixel(16'hFFFF, 16'h1000);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: apply_setting(1'b1, 16'd1, 16'd0, 16'hFFFF);
				1: apply_setting(1'b0, 16'hFFFF, 16'hFFFF, 16'd0);
				2: apply_setting(1'b1, 16'($urandom_range(64, 2048)),
					16'($urandom_range(0, 4096)), 16'($urandom_range(32768, 65535)));
				3: apply_setting(1'b0, 16'($urandom_range(64, 2048)),
					16'($urandom_range(0, 4096)), 16'($urandom_range(32768, 65535)));
				4: apply_setting(1'b0, 16'd1, 16'd0, 16'hFFFF);
				default: apply_setting(1'b1, 16'hFFFF, 16'($urandom),
					16'($urandom));
			endcase
			if (ph == 0)
				steady = 1'b1;
			if (ph == 2) begin
				// output held off while requests keep coming, so the pipeline backs up
				hold_req = 1'b1;
				steady   = 1'b1;
				repeat (80) random_request();
				steady   = 1'b0;
			end
			for (int n = 0; n < ((ph == 1) ? 120 : 280); n++) begin
				if (ph == 0 && n == 200)
					steady = 1'b0;
				if (ph == 3 && n == 170)
					drain();
				random_request();
			end
		end

		drain();
		$display("covered %0d pixel requests and %0d table writes over %0d register settings",
			pixels, writes, settings + 1);
		$display("%0d certainty results compared, %0d mismatches", compared, fail_count);
		if (fail_count == 0)
			$display("PASS hdr_ghost_certainty_pixel_top");
		else
			$display("FAIL hdr_ghost_certainty_pixel_top");
		$finish;
	end

endmodule

@@ files.f @@
rtl/hgc_pkg.sv
rtl/hgc_ram.sv
rtl/hgc_cfg_regs.sv
rtl/hgc_div_stage.sv
rtl/hdr_ghost_certainty_pixel_top.sv
dv/hgc_tb_pkg.sv
dv/hgc_certainty_checker.sv
dv/hdr_ghost_certainty_pixel_top_tb.sv
